@@ rtl/olks_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// olks_pkg
// Shared widths, command codes and status codes of the ordered list block.
// ---------------------------------------------------------------------------
package olks_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT = 32;

    localparam int KEY_W      = 32;
    localparam int PAY_PORT_W = 32;
    localparam int PAY_WIDE_W = 64;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_FIND      = 3'd2;
    localparam logic [2:0] CMD_REMOVE    = 3'd3;
    localparam logic [2:0] CMD_POP       = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

endpackage
`default_nettype wire

@@ rtl/olks_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// olks_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module olks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/ordered_list_with_key_search.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ordered_list_with_key_search
// Bounded doubly linked list of key/payload entries held in slot RAMs, with
// insert at either end, find, remove of the first match and pop of the front.
// ---------------------------------------------------------------------------
// Operation: find and remove read and check the entries from the front; pop takes
//   the front entry; an insert probes slots upward from index 0 for the lowest
//   free one, then writes and links it; full, empty and bad-command cases go
//   straight to the result. Throughput: one transaction at a time; the next is
//   taken once the result is in the output register. Reset: asynchronous; then a
//   pass over every slot clears the slot-used RAM while in_stall stays high.
module ordered_list_with_key_search
    import olks_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              command,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic [PAY_PORT_W-1:0]   payload,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   status,
    output logic signed [KEY_W-1:0]      out_key,
    output logic [PAY_PORT_W-1:0]        out_payload,
    output logic                         list_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = PAYLOAD_WIDTH;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_RD,
        S_FREE_CHK,
        S_INS_LINK,
        S_INS_FIX,
        S_WALK_RD,
        S_WALK_CHK,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [CW-1:0]           walk_cnt_reg, walk_cnt_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           front_reg, front_next;
    logic [AW-1:0]           back_reg, back_next;
    logic [2:0]              cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PW-1:0]           pay_reg, pay_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [PAY_PORT_W-1:0]   res_pay_reg, res_pay_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic [KEY_W-1:0]        out_key_reg, out_key_next;
    logic [PAY_PORT_W-1:0]   out_payload_reg, out_payload_next;
    logic                    list_empty_reg, list_empty_next;

    logic                    key_we, pay_we, used_we, next_we, prev_we;
    logic [AW-1:0]           used_waddr, next_waddr, prev_waddr;
    logic                    used_wdata;
    logic [AW-1:0]           next_wdata, prev_wdata;
    logic [KEY_W-1:0]        key_rd;
    logic [PW-1:0]           pay_rd;
    logic [AW-1:0]           next_rd, prev_rd;
    logic                    used_rd;

    logic [PAY_WIDE_W-1:0]   pay_in_wide;
    logic [PAY_WIDE_W-1:0]   pay_rd_wide;
    logic                    hit;

    assign pay_in_wide = PAY_WIDE_W'(payload);
    assign pay_rd_wide = PAY_WIDE_W'(pay_rd);
    assign hit         = (cmd_reg == CMD_POP) || (key_rd == key_reg);

    // All RAMs are read at the current slot; the read data is registered.
    olks_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_keys (
        .clk(clk), .we(key_we), .waddr(cur_reg), .wdata(key_reg),
        .raddr(cur_reg), .rdata(key_rd)
    );

    olks_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pays (
        .clk(clk), .we(pay_we), .waddr(cur_reg), .wdata(pay_reg),
        .raddr(cur_reg), .rdata(pay_rd)
    );

    olks_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(cur_reg), .rdata(next_rd)
    );

    olks_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev (
        .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(cur_reg), .rdata(prev_rd)
    );

    olks_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_used (
        .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
        .raddr(cur_reg), .rdata(used_rd)
    );

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        walk_cnt_next    = walk_cnt_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        pay_next         = pay_reg;
        res_status_next  = res_status_reg;
        res_key_next     = res_key_reg;
        res_pay_next     = res_pay_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        out_key_next     = out_key_reg;
        out_payload_next = out_payload_reg;
        list_empty_next  = list_empty_reg;

        key_we     = 1'b0;
        pay_we     = 1'b0;
        used_we    = 1'b0;
        used_waddr = cur_reg;
        used_wdata = 1'b0;
        next_we    = 1'b0;
        next_waddr = cur_reg;
        next_wdata = cur_reg;
        prev_we    = 1'b0;
        prev_waddr = cur_reg;
        prev_wdata = cur_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                used_we = 1'b1;
                if (cur_reg == AW'(DEPTH - 1))
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    key_next        = key;
                    pay_next        = pay_in_wide[PW-1:0];
                    res_status_next = ST_OK;
                    res_key_next    = '0;
                    res_pay_next    = '0;
                    walk_cnt_next   = '0;
                    state_next      = S_DONE;
                    unique case (command)
                        CMD_INS_FRONT, CMD_INS_BACK:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                cur_next   = '0;
                                state_next = S_FREE_RD;
                            end
                        end
                        CMD_FIND, CMD_REMOVE, CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_MISS;
                            end
                            else
                            begin
                                cur_next   = front_reg;
                                state_next = S_WALK_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_BAD;
                        end
                    endcase
                end
            end

            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                if (!used_rd)
                begin
                    state_next = S_INS_LINK;
                end
                else
                begin
                    cur_next   = cur_reg + AW'(1);
                    state_next = S_FREE_RD;
                end
            end

            S_INS_LINK:
            begin
                // The new entry sits in the free slot at cur_reg.
                key_we     = 1'b1;
                pay_we     = 1'b1;
                used_we    = 1'b1;
                used_wdata = 1'b1;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                if (count_reg == '0)
                begin
                    front_next = cur_reg;
                    back_next  = cur_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    if (cmd_reg == CMD_INS_FRONT)
                    begin
                        next_wdata = front_reg;
                    end
                    else
                    begin
                        prev_wdata = back_reg;
                    end
                    state_next = S_INS_FIX;
                end
            end

            S_INS_FIX:
            begin
                // Point the old end entry at the new one.
                if (cmd_reg == CMD_INS_FRONT)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = front_reg;
                    front_next = cur_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = back_reg;
                    back_next  = cur_reg;
                end
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                if (hit)
                begin
                    res_key_next = key_rd;
                    if (cmd_reg != CMD_POP)
                    begin
                        res_pay_next = pay_rd_wide[PAY_PORT_W-1:0];
                    end
                    if (cmd_reg != CMD_FIND)
                    begin
                        used_we = 1'b1;
                        if (cur_reg == front_reg)
                        begin
                            front_next = next_rd;
                        end
                        else
                        begin
                            next_we    = 1'b1;
                            next_waddr = prev_rd;
                            next_wdata = next_rd;
                        end
                        if (cur_reg == back_reg)
                        begin
                            back_next = prev_rd;
                        end
                        else
                        begin
                            prev_we    = 1'b1;
                            prev_waddr = next_rd;
                            prev_wdata = prev_rd;
                        end
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_DONE;
                end
                else if (walk_cnt_reg + CW'(1) == count_reg)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg + CW'(1);
                    cur_next      = next_rd;
                    state_next    = S_WALK_RD;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    out_key_next     = res_key_reg;
                    out_payload_next = res_pay_reg;
                    list_empty_next  = (count_reg == '0);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cur_reg         <= '0;
            walk_cnt_reg    <= '0;
            count_reg       <= '0;
            front_reg       <= '0;
            back_reg        <= '0;
            cmd_reg         <= '0;
            key_reg         <= '0;
            pay_reg         <= '0;
            res_status_reg  <= ST_OK;
            res_key_reg     <= '0;
            res_pay_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            out_key_reg     <= '0;
            out_payload_reg <= '0;
            list_empty_reg  <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            walk_cnt_reg    <= walk_cnt_next;
            count_reg       <= count_next;
            front_reg       <= front_next;
            back_reg        <= back_next;
            cmd_reg         <= cmd_next;
            key_reg         <= key_next;
            pay_reg         <= pay_next;
            res_status_reg  <= res_status_next;
            res_key_reg     <= res_key_next;
            res_pay_reg     <= res_pay_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            out_key_reg     <= out_key_next;
            out_payload_reg <= out_payload_next;
            list_empty_reg  <= list_empty_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign list_empty  = list_empty_reg;

endmodule
`default_nettype wire

@@ sim/ordered_list_with_key_search_test.sv @@
// ----------------------------------------------------------------------------
// ordered_list_with_key_search_test
// Self-checking bench for the ordered key/payload list. A directed opening
// covers the empty list, bad command codes, the field extremes, duplicate keys
// and removal at the front, middle and back. Random fill, drain and mixed
// sequences then follow, with random idling on both handshakes. A scoreboard
// keeps its own copy of the list order and checks every returned transaction.
// ----------------------------------------------------------------------------
module ordered_list_with_key_search_test
    import olks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_PRINTED    = 40;

    // Codes above the last defined command are rejected by the block.
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_PORT_W-1:0]   pay;
    } entry_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key;
        logic [PAY_PORT_W-1:0]   pay;
        logic                    empty;
    } result_t;

    class list_scoreboard;
        entry_t  chain[$];
        result_t awaited_results[$];
        int      errors;
        int      checked;
        int      n_insert;
        int      n_full;
        int      n_hit;
        int      n_miss;
        int      n_bad;
        int      max_size;

        function new();
            errors   = 0;
            checked  = 0;
            n_insert = 0;
            n_full   = 0;
            n_hit    = 0;
            n_miss   = 0;
            n_bad    = 0;
            max_size = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Applies one accepted command to the list copy and queues its result.
        task note_command(logic [2:0] cmd, logic signed [KEY_W-1:0] k,
                          logic [PAY_PORT_W-1:0] p);
            result_t r;
            entry_t  e;
            int      idx;
            r   = '0;
            e   = '0;
            idx = -1;
            r.status = ST_OK;
            case (cmd)
                CMD_INS_FRONT, CMD_INS_BACK:
                begin
                    if (chain.size() >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        e.key = k;
                        e.pay = p;
                        if (cmd == CMD_INS_FRONT)
                            chain.push_front(e);
                        else
                            chain.push_back(e);
                        n_insert++;
                    end
                end
                CMD_FIND, CMD_REMOVE:
                begin
                    // The first match from the front wins.
                    for (int i = 0; i < chain.size() && idx < 0; i++)
                        if (chain[i].key == k)
                            idx = i;
                    if (idx < 0)
                    begin
                        r.status = ST_MISS;
                        n_miss++;
                    end
                    else
                    begin
                        r.key = chain[idx].key;
                        r.pay = chain[idx].pay;
                        if (cmd == CMD_REMOVE)
                            chain.delete(idx);
                        n_hit++;
                    end
                end
                CMD_POP:
                begin
                    if (chain.size() == 0)
                    begin
                        r.status = ST_MISS;
                        n_miss++;
                    end
                    else
                    begin
                        // A pop hands back the key only.
                        r.key = chain[0].key;
                        void'(chain.pop_front());
                        n_hit++;
                    end
                end
                default:
                begin
                    r.status = ST_BAD;
                    n_bad++;
                end
            endcase
            r.empty = (chain.size() == 0);
            if (chain.size() > max_size)
                max_size = chain.size();
            awaited_results.push_back(r);
        endtask

        task check_result(logic [1:0] st, logic signed [KEY_W-1:0] k,
                          logic [PAY_PORT_W-1:0] p, logic e);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding (status %0d key %h)", st, k));
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (st !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 checked, st, want.status));
            if (k !== want.key)
                report($sformatf("result %0d out_key %h, expected %h", checked, k, want.key));
            if (p !== want.pay)
                report($sformatf("result %0d out_payload %h, expected %h",
                                 checked, p, want.pay));
            if (e !== want.empty)
                report($sformatf("result %0d list_empty %b, expected %b",
                                 checked, e, want.empty));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [2:0]              command;
    logic signed [KEY_W-1:0] key;
    logic [PAY_PORT_W-1:0]   payload;
    logic                    out_valid;
    logic                    out_stall;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_PORT_W-1:0]   out_payload;
    logic                    list_empty;

    list_scoreboard sb;
    bit             calm;
    int             items_sent;
    int             idle_cycles;

    ordered_list_with_key_search #(
        .DEPTH         (DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH_DEFAULT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .key         (key),
        .payload     (payload),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_key     (out_key),
        .out_payload (out_payload),
        .list_empty  (list_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keys mostly repeat what is stored or come from a tiny pool, so that finds
    // hit and duplicates are common; the rest are full-width random values.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && sb.chain.size() > 0)
            return sb.chain[$urandom_range(0, sb.chain.size() - 1)].key;
        if (r < 8)
            return $signed($urandom_range(0, 7)) - 3;
        return $urandom;
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic signed [KEY_W-1:0] k,
                            input logic [PAY_PORT_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        payload  <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_command(cmd, k, p);
        items_sent++;
    endtask

    task automatic send_mixed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            send_cmd(CMD_INS_FRONT, pick_key(), $urandom);
        else if (r < 40)
            send_cmd(CMD_INS_BACK, pick_key(), $urandom);
        else if (r < 60)
            send_cmd(CMD_FIND, pick_key(), $urandom);
        else if (r < 78)
            send_cmd(CMD_REMOVE, pick_key(), $urandom);
        else if (r < 92)
            send_cmd(CMD_POP, pick_key(), $urandom);
        else
            send_cmd(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), $urandom, $urandom);
    endtask

    task automatic run_random();
        int seq;
        int n;
        while (items_sent < RANDOM_ITEMS)
        begin
            seq  = $urandom_range(0, 9);
            calm = ($urandom_range(0, 5) == 0);
            if (seq < 2)
            begin
                // Fill until full, then knock on the full store.
                while (sb.chain.size() < DEPTH)
                    send_cmd($urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT,
                             pick_key(), $urandom);
                repeat ($urandom_range(1, 2))
                    send_cmd($urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT,
                             pick_key(), $urandom);
            end
            else if (seq < 4)
            begin
                while (sb.chain.size() > 0)
                begin
                    if ($urandom_range(0, 1))
                        send_cmd(CMD_POP, $urandom, $urandom);
                    else
                        send_cmd(CMD_REMOVE,
                                 sb.chain[$urandom_range(0, sb.chain.size() - 1)].key,
                                 $urandom);
                end
                send_cmd(3'($urandom_range(CMD_FIND, CMD_POP)), pick_key(), $urandom);
            end
            else if (seq < 9)
            begin
                n = $urandom_range(10, 30);
                repeat (n)
                    send_mixed();
            end
            else
            begin
                n = $urandom_range(3, 8);
                repeat (n)
                    if ($urandom_range(0, 1))
                        send_cmd(3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI)), $urandom, $urandom);
                    else
                        send_cmd(CMD_FIND, $urandom, $urandom);
            end
        end
        calm = 1'b0;
    endtask

    // Result side: random back-pressure, checked at every accepted transaction.
    initial
    begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(status, out_key, out_payload, list_empty);
            if (calm)
            begin
                hold = 0;
                out_stall <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 30)
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        sb         = new();
        calm       = 1'b0;
        items_sent = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        command  <= CMD_INS_FRONT;
        key      <= '0;
        payload  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list and rejected codes.
        send_cmd(CMD_POP, 32'sd0, 32'h0);
        send_cmd(CMD_FIND, 32'sd0, 32'h0);
        send_cmd(CMD_REMOVE, 32'sd0, 32'h0);
        send_cmd(CMD_BAD_LO, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_BAD_LO + 3'd1, 32'sh8000_0000, 32'h0);
        send_cmd(CMD_BAD_HI, -32'sd1, 32'h5A5A_5A5A);

        // Extremes of key and payload, then a duplicated key.
        send_cmd(CMD_INS_BACK, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_INS_FRONT, 32'sh8000_0000, 32'h0);
        send_cmd(CMD_INS_BACK, 32'sd5, 32'h1111_1111);
        send_cmd(CMD_INS_FRONT, -32'sd1, 32'hA5A5_A5A5);
        send_cmd(CMD_INS_BACK, 32'sd5, 32'h2222_2222);
        send_cmd(CMD_BAD_HI, 32'sd5, 32'h0);

        // Duplicates resolve to the first match; then removal at each position.
        send_cmd(CMD_FIND, 32'sd5, 32'h0);
        send_cmd(CMD_REMOVE, 32'sd5, 32'h0);
        send_cmd(CMD_FIND, 32'sd5, 32'h0);
        send_cmd(CMD_FIND, 32'sd123, 32'h0);
        send_cmd(CMD_REMOVE, 32'sd5, 32'h0);
        send_cmd(CMD_REMOVE, 32'sh8000_0000, 32'h0);
        send_cmd(CMD_INS_BACK, 32'sd9, 32'h0F0F_0F0F);
        send_cmd(CMD_POP, 32'sd0, 32'h0);
        send_cmd(CMD_POP, 32'sd0, 32'h0);
        send_cmd(CMD_POP, 32'sd0, 32'h0);
        send_cmd(CMD_POP, 32'sd0, 32'h0);

        run_random();
        in_valid <= 1'b0;

        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands, checked %0d results: %0d inserts, %0d store-full,",
                 items_sent, sb.checked, sb.n_insert, sb.n_full);
        $display("%0d hits, %0d misses, %0d bad codes; list reached %0d entries; %0d mismatches.",
                 sb.n_hit, sb.n_miss, sb.n_bad, sb.max_size, sb.errors);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/olks_pkg.sv
rtl/olks_ram.sv
rtl/ordered_list_with_key_search.sv
sim/ordered_list_with_key_search_test.sv
